>>> src/i2crts_pkg.sv
package i2crts_pkg;

	typedef enum logic [1:0] {
		CMD_BEGIN_READ  = 2'd0,
		CMD_BEGIN_WRITE = 2'd1,
		CMD_BUS_REPLY   = 2'd2,
		CMD_WRITE_DATA  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		OP_NONE    = 3'd0,
		OP_START   = 3'd1,
		OP_SEND    = 3'd2,
		OP_RX_ACK  = 3'd3,
		OP_RX_NACK = 3'd4,
		OP_STOP    = 3'd5
	} bus_op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ADDR_NACK = 3'd1,
		ST_REG_NACK  = 3'd2,
		ST_DATA_NACK = 3'd3,
		ST_ZERO_READ = 3'd4
	} status_t;

	typedef enum logic [9:0] {
		PH_IDLE       = 10'b00_0000_0001,
		PH_ADDR_START = 10'b00_0000_0010,
		PH_ADDR_SENT  = 10'b00_0000_0100,
		PH_REG_SENT   = 10'b00_0000_1000,
		PH_RSTART     = 10'b00_0001_0000,
		PH_RADDR_SENT = 10'b00_0010_0000,
		PH_RECEIVING  = 10'b00_0100_0000,
		PH_WAIT_DATA  = 10'b00_1000_0000,
		PH_DATA_SENT  = 10'b01_0000_0000,
		PH_STOPPING   = 10'b10_0000_0000
	} phase_t;

	localparam logic [7:0] RETRY_LIMIT_RESET = 8'd100;
	localparam int unsigned PADDR_W = 3;
	localparam logic REG_RETRY_LIMIT = 1'b0;

	typedef struct packed {
		logic [1:0] command;
		logic [6:0] device_address;
		logic [7:0] register_address;
		logic [7:0] byte_count;
		logic       ack_received;
		logic [7:0] received_byte;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [2:0] bus_op;
		logic [7:0] send_byte;
		logic [7:0] read_data;
		logic       read_valid;
		logic       data_request;
		logic       done_res;
		logic [2:0] status;
	} rsp_t;

endpackage

>>> src/i2crts_if.sv
interface i2crts_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [6:0] device_address;
	logic [7:0] register_address;
	logic [7:0] byte_count;
	logic       ack_received;
	logic [7:0] received_byte;
	logic [7:0] data_byte;

	modport source (
		output valid, command, device_address, register_address, byte_count,
			ack_received, received_byte, data_byte,
		input ready
	);
	modport sink (
		input valid, command, device_address, register_address, byte_count,
			ack_received, received_byte, data_byte,
		output ready
	);
endinterface

interface i2crts_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] bus_op;
	logic [7:0] send_byte;
	logic [7:0] read_data;
	logic       read_valid;
	logic       data_request;
	logic       done_res;
	logic [2:0] status;

	modport source (
		output valid, bus_op, send_byte, read_data, read_valid, data_request,
			done_res, status,
		input ready
	);
	modport sink (
		input valid, bus_op, send_byte, read_data, read_valid, data_request,
			done_res, status,
		output ready
	);
endinterface

>>> src/i2crts_apb.sv
module i2crts_apb
	import i2crts_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [7:0]         retry_limit
);

	logic [7:0] retry_limit_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// low address bits are ignored; paddr[2] selects the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_LIMIT_RESET;
		end else if (wr_en && paddr[2] == REG_RETRY_LIMIT) begin
			retry_limit_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_RETRY_LIMIT) begin
			prdata = {24'd0, retry_limit_q};
		end
	end

	assign retry_limit = retry_limit_q;

endmodule

>>> src/i2crts_fsm.sv
module i2crts_fsm
	import i2crts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  req_t       req,
	input  logic [7:0] retry_limit,
	output rsp_t       rsp
);

	phase_t     phase_q, phase_d;
	logic       is_read_q, is_read_d;
	logic [7:0] attempts_q, attempts_d;
	logic [7:0] bytes_q, bytes_d;
	logic [6:0] target_q, target_d;
	logic [7:0] start_reg_q, start_reg_d;
	logic [7:0] bytes_dec;

	assign bytes_dec = bytes_q - 8'd1;

	always_comb begin
		phase_d     = phase_q;
		is_read_d   = is_read_q;
		attempts_d  = attempts_q;
		bytes_d     = bytes_q;
		target_d    = target_q;
		start_reg_d = start_reg_q;
		rsp         = '0;

		case (cmd_t'(req.command))
			CMD_BEGIN_READ, CMD_BEGIN_WRITE: begin
				if (phase_q == PH_IDLE) begin
					is_read_d   = (req.command == CMD_BEGIN_READ);
					target_d    = req.device_address;
					start_reg_d = req.register_address;
					bytes_d     = req.byte_count;
					attempts_d  = retry_limit;
					rsp.bus_op  = OP_START;
					phase_d     = PH_ADDR_START;
				end
			end
			CMD_WRITE_DATA: begin
				if (phase_q == PH_WAIT_DATA) begin
					rsp.bus_op    = OP_SEND;
					rsp.send_byte = req.data_byte;
					bytes_d       = bytes_dec;
					phase_d       = PH_DATA_SENT;
				end
			end
			CMD_BUS_REPLY: begin
				case (phase_q)
					PH_ADDR_START: begin
						rsp.bus_op    = OP_SEND;
						rsp.send_byte = {target_q, 1'b0};
						phase_d       = PH_ADDR_SENT;
					end
					PH_ADDR_SENT: begin
						if (req.ack_received) begin
							rsp.bus_op    = OP_SEND;
							rsp.send_byte = start_reg_q;
							phase_d       = PH_REG_SENT;
						end else if (attempts_q > 8'd1) begin
							attempts_d = attempts_q - 8'd1;
							rsp.bus_op = OP_START;
							phase_d    = PH_ADDR_START;
						end else begin
							rsp.done_res = 1'b1;
							rsp.status   = ST_ADDR_NACK;
							phase_d      = PH_IDLE;
						end
					end
					PH_REG_SENT: begin
						if (is_read_q) begin
							if (!req.ack_received) begin
								rsp.done_res = 1'b1;
								rsp.status   = ST_REG_NACK;
								phase_d      = PH_IDLE;
							end else begin
								attempts_d = retry_limit;
								rsp.bus_op = OP_START;
								phase_d    = PH_RSTART;
							end
						end else if (bytes_q == 8'd0) begin
							rsp.bus_op = OP_STOP;
							phase_d    = PH_STOPPING;
						end else if (!req.ack_received) begin
							rsp.done_res = 1'b1;
							rsp.status   = ST_REG_NACK;
							phase_d      = PH_IDLE;
						end else begin
							rsp.data_request = 1'b1;
							phase_d          = PH_WAIT_DATA;
						end
					end
					PH_RSTART: begin
						rsp.bus_op    = OP_SEND;
						rsp.send_byte = {target_q, 1'b1};
						phase_d       = PH_RADDR_SENT;
					end
					PH_RADDR_SENT: begin
						if (req.ack_received) begin
							if (bytes_q == 8'd0) begin
								rsp.done_res = 1'b1;
								rsp.status   = ST_ZERO_READ;
								phase_d      = PH_IDLE;
							end else begin
								rsp.bus_op = (bytes_q == 8'd1) ? OP_RX_NACK : OP_RX_ACK;
								phase_d    = PH_RECEIVING;
							end
						end else if (attempts_q > 8'd1) begin
							attempts_d = attempts_q - 8'd1;
							rsp.bus_op = OP_START;
							phase_d    = PH_RSTART;
						end else begin
							rsp.done_res = 1'b1;
							rsp.status   = ST_ADDR_NACK;
							phase_d      = PH_IDLE;
						end
					end
					PH_RECEIVING: begin
						rsp.read_data  = req.received_byte;
						rsp.read_valid = 1'b1;
						bytes_d        = bytes_dec;
						if (bytes_dec == 8'd0) begin
							rsp.bus_op = OP_STOP;
							phase_d    = PH_STOPPING;
						end else begin
							// nack the last byte
							rsp.bus_op = (bytes_dec == 8'd1) ? OP_RX_NACK : OP_RX_ACK;
						end
					end
					PH_DATA_SENT: begin
						if (bytes_q == 8'd0) begin
							rsp.bus_op = OP_STOP;
							phase_d    = PH_STOPPING;
						end else if (!req.ack_received) begin
							rsp.done_res = 1'b1;
							rsp.status   = ST_DATA_NACK;
							phase_d      = PH_IDLE;
						end else begin
							rsp.data_request = 1'b1;
							phase_d          = PH_WAIT_DATA;
						end
					end
					PH_STOPPING: begin
						rsp.done_res = 1'b1;
						rsp.status   = ST_OK;
						phase_d      = PH_IDLE;
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
			default: begin
				rsp = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			is_read_q   <= 1'b0;
			attempts_q  <= '0;
			bytes_q     <= '0;
			target_q    <= '0;
			start_reg_q <= '0;
		end else if (adv) begin
			phase_q     <= phase_d;
			is_read_q   <= is_read_d;
			attempts_q  <= attempts_d;
			bytes_q     <= bytes_d;
			target_q    <= target_d;
			start_reg_q <= start_reg_d;
		end
	end

endmodule

>>> src/i2c_register_transaction_sequencer.sv
// The result register loads from the input register once an item is accepted there and the
// result stage is empty or its result is being taken.
// Throughput: one item per cycle while the result is taken; the sequencer state advances
// as each item leaves the input register.
// Reset (arst_n low, asynchronous): both stages empty, sequencer idle, retry limit 100.
module i2c_register_transaction_sequencer
	import i2crts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	i2crts_item_if.sink          item,
	i2crts_result_if.source      result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic       valid_s1;
	req_t       req_s1;
	logic       valid_s2;
	rsp_t       rsp_s2;
	rsp_t       rsp_comb;
	logic       adv;
	logic [7:0] retry_limit;

	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			req_s1 <= '{
				command:          item.command,
				device_address:   item.device_address,
				register_address: item.register_address,
				byte_count:       item.byte_count,
				ack_received:     item.ack_received,
				received_byte:    item.received_byte,
				data_byte:        item.data_byte
			};
		end
	end

	i2crts_apb u_apb (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.retry_limit (retry_limit)
	);

	i2crts_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.req         (req_s1),
		.retry_limit (retry_limit),
		.rsp         (rsp_comb)
	);

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s2 <= rsp_comb;
		end
	end

	assign result.valid        = valid_s2;
	assign result.bus_op       = rsp_s2.bus_op;
	assign result.send_byte    = rsp_s2.send_byte;
	assign result.read_data    = rsp_s2.read_data;
	assign result.read_valid   = rsp_s2.read_valid;
	assign result.data_request = rsp_s2.data_request;
	assign result.done_res     = rsp_s2.done_res;
	assign result.status       = rsp_s2.status;

endmodule

>>> src/i2crts_checker.sv
module i2crts_checker
	import i2crts_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] res_bus_op,
	input logic [7:0] res_send_byte,
	input logic [7:0] res_read_data,
	input logic       res_read_valid,
	input logic       res_data_request,
	input logic       res_done_res,
	input logic [2:0] res_status
);

	// a stalled transaction keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_bus_op)
			&& $stable(res_send_byte) && $stable(res_read_data)
			&& $stable(res_status) && $stable(res_done_res))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_done_res |-> res_status == ST_OK)
		else $error("status without completion");

	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_done_res |-> res_bus_op == OP_NONE && !res_data_request
			&& !res_read_valid)
		else $error("completion carries a bus primitive");

	a_rx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_read_valid |-> res_bus_op == OP_STOP
			|| res_bus_op == OP_RX_ACK || res_bus_op == OP_RX_NACK)
		else $error("received byte without receive or stop");

	a_send: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_bus_op != OP_SEND |-> res_send_byte == 8'd0)
		else $error("send byte outside send primitive");

endmodule

bind i2c_register_transaction_sequencer i2crts_checker u_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (result.valid),
	.res_ready        (result.ready),
	.res_bus_op       (result.bus_op),
	.res_send_byte    (result.send_byte),
	.res_read_data    (result.read_data),
	.res_read_valid   (result.read_valid),
	.res_data_request (result.data_request),
	.res_done_res     (result.done_res),
	.res_status       (result.status)
);
